>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define AFFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define AFFW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/affw_pkg.sv
// ----------------------------------------------------------------------------
// affw_pkg
// types and constants shared by the affine warp core
// ----------------------------------------------------------------------------
`default_nettype none

package affw_pkg;

  localparam int COORD_W    = 8;
  localparam int GRAY_W     = 8;
  localparam int COEF_W     = 16;
  localparam int FRAME_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int D_W        = 18;
  localparam int P_W        = 34;
  localparam int S_W        = 35;
  localparam int FRAC_BITS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_M00          = 3'd0,
    CFG_M01          = 3'd1,
    CFG_M10          = 3'd2,
    CFG_M11          = 3'd3,
    CFG_SHIFT_X      = 3'd4,
    CFG_SHIFT_Y      = 3'd5,
    CFG_FRAME_WIDTH  = 3'd6,
    CFG_FRAME_HEIGHT = 3'd7
  } cfg_idx_t;

  localparam logic [COEF_W-1:0]  M_ONE        = 16'd4096;
  localparam logic [FRAME_W-1:0] FRAME_RESET  = 9'd256;

  typedef struct packed {
    logic [COEF_W-1:0]  m00;
    logic [COEF_W-1:0]  m01;
    logic [COEF_W-1:0]  m10;
    logic [COEF_W-1:0]  m11;
    logic [COEF_W-1:0]  shift_x;
    logic [COEF_W-1:0]  shift_y;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic in_frame;
    logic wr_en;
  } map_ctl_t;

endpackage

`default_nettype wire

>>> design/affw_ram.sv
// ----------------------------------------------------------------------------
// affw_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module affw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> design/affw_cfg.sv
// ----------------------------------------------------------------------------
// affw_cfg
// configuration register file for the warp matrix, shift and frame size
// ----------------------------------------------------------------------------
`default_nettype none

module affw_cfg import affw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_M00:          cfg_nxt.m00          = cfg_data;
        CFG_M01:          cfg_nxt.m01          = cfg_data;
        CFG_M10:          cfg_nxt.m10          = cfg_data;
        CFG_M11:          cfg_nxt.m11          = cfg_data;
        CFG_SHIFT_X:      cfg_nxt.shift_x      = cfg_data;
        CFG_SHIFT_Y:      cfg_nxt.shift_y      = cfg_data;
        CFG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data[FRAME_W-1:0];
        CFG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[FRAME_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.m00          <= M_ONE;
      cfg_r.m01          <= '0;
      cfg_r.m10          <= '0;
      cfg_r.m11          <= M_ONE;
      cfg_r.shift_x      <= '0;
      cfg_r.shift_y      <= '0;
      cfg_r.frame_width  <= FRAME_RESET;
      cfg_r.frame_height <= FRAME_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/affw_map.sv
// ----------------------------------------------------------------------------
// affw_map
// four-stage coordinate pipeline: offset, products, sums, bounds and address
// ----------------------------------------------------------------------------
`default_nettype none

module affw_map import affw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  cfg_t                     cfg,
  input  wire logic                s_valid,
  output logic                     s_ready,
  input  wire logic                s_op,
  input  wire logic [COORD_W-1:0]  s_col,
  input  wire logic [COORD_W-1:0]  s_row,
  input  wire logic [GRAY_W-1:0]   s_pix,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output map_ctl_t                 m_ctl,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] m_addr,
  output logic [GRAY_W-1:0]        m_pix
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // item info carried along
  logic               op1_r, op2_r, op3_r;
  logic               wok1_r, wok2_r, wok3_r;
  logic [COORD_W-1:0] col1_r, col2_r, col3_r;
  logic [COORD_W-1:0] row1_r, row2_r, row3_r;
  logic [GRAY_W-1:0]  pix1_r, pix2_r, pix3_r, pix4_r;

  logic signed [D_W-1:0] dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic signed [P_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [P_W-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic signed [S_W-1:0] sx3_r, sy3_r, sx3_nxt, sy3_nxt;

  map_ctl_t        ctl4_r, ctl4_nxt;
  logic [AW-1:0]   addr4_r, addr4_nxt;
  logic            wok1_nxt;
  logic [FRAME_W-1:0] w_eff, h_eff;
  logic            in_x, in_y;
  logic [FRAME_W-1:0] col_sel, row_sel;

  assign rdy4    = !v4_r || m_ready;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;

  assign m_valid = v4_r;
  assign m_ctl   = ctl4_r;
  assign m_addr  = addr4_r;
  assign m_pix   = pix4_r;

  assign w_eff = (32'(cfg.frame_width) < MAX_WIDTH) ? cfg.frame_width : FRAME_W'(MAX_WIDTH);
  assign h_eff = (32'(cfg.frame_height) < MAX_HEIGHT) ? cfg.frame_height
                                                       : FRAME_W'(MAX_HEIGHT);

  // stage 1: offset removal
  always_comb begin
    dx1_nxt  = $signed({6'b0, s_col, 4'b0000})
             - $signed({{2{cfg.shift_x[COEF_W-1]}}, cfg.shift_x});
    dy1_nxt  = $signed({6'b0, s_row, 4'b0000})
             - $signed({{2{cfg.shift_y[COEF_W-1]}}, cfg.shift_y});
    wok1_nxt = (32'(s_col) < MAX_WIDTH) && (32'(s_row) < MAX_HEIGHT);
  end

  // stage 2: matrix products
  always_comb begin
    p00_nxt = P_W'($signed(cfg.m00)) * P_W'(dx1_r);
    p01_nxt = P_W'($signed(cfg.m01)) * P_W'(dy1_r);
    p10_nxt = P_W'($signed(cfg.m10)) * P_W'(dx1_r);
    p11_nxt = P_W'($signed(cfg.m11)) * P_W'(dy1_r);
  end

  // stage 3: sums
  always_comb begin
    sx3_nxt = $signed({p00_r[P_W-1], p00_r}) + $signed({p01_r[P_W-1], p01_r});
    sy3_nxt = $signed({p10_r[P_W-1], p10_r}) + $signed({p11_r[P_W-1], p11_r});
  end

  // stage 4: bounds check, truncation and frame address
  always_comb begin
    in_x = !sx3_r[S_W-1] &&
           (sx3_r[S_W-2:FRAC_BITS] < {{(S_W-1-FRAC_BITS-FRAME_W){1'b0}}, w_eff});
    in_y = !sy3_r[S_W-1] &&
           (sy3_r[S_W-2:FRAC_BITS] < {{(S_W-1-FRAC_BITS-FRAME_W){1'b0}}, h_eff});
    ctl4_nxt.in_frame = op3_r && in_x && in_y;
    ctl4_nxt.wr_en    = !op3_r && wok3_r;
    col_sel   = op3_r ? sx3_r[FRAC_BITS+FRAME_W-1:FRAC_BITS] : FRAME_W'(col3_r);
    row_sel   = op3_r ? sy3_r[FRAC_BITS+FRAME_W-1:FRAC_BITS] : FRAME_W'(row3_r);
    addr4_nxt = AW'(row_sel) * AW'(MAX_WIDTH) + AW'(col_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= s_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r  <= s_op;
      wok1_r <= wok1_nxt;
      col1_r <= s_col;
      row1_r <= s_row;
      pix1_r <= s_pix;
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
    end
    if (rdy2) begin
      op2_r  <= op1_r;
      wok2_r <= wok1_r;
      col2_r <= col1_r;
      row2_r <= row1_r;
      pix2_r <= pix1_r;
      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
    end
    if (rdy3) begin
      op3_r  <= op2_r;
      wok3_r <= wok2_r;
      col3_r <= col2_r;
      row3_r <= row2_r;
      pix3_r <= pix2_r;
      sx3_r  <= sx3_nxt;
      sy3_r  <= sy3_nxt;
    end
    if (rdy4) begin
      ctl4_r  <= ctl4_nxt;
      addr4_r <= addr4_nxt;
      pix4_r  <= pix3_r;
    end
  end

endmodule

`default_nettype wire

>>> design/affine_nearest_image_warp_core.sv
// ----------------------------------------------------------------------------
// affine_nearest_image_warp_core
// inverse-mapped affine warp of a stored gray frame, nearest-neighbor sampling
// ----------------------------------------------------------------------------
// usage
//   in channel: op 0 writes in_pixel_in at (in_col, in_row) into the frame
//   store, op 1 queries output pixel (in_col, in_row). every input transfer
//   gives exactly one result transfer, in order; a write answers 0, inside 0.
//   cfg channel: 8 registers (matrix, shift, frame size), always ready;
//   write them only while no item is in flight.
//   each item passes the offset, products, sums and bounds/address stages,
//   then the frame ram read which also serves as the output register.
//   throughput: one item per cycle while the output is not stalled; the
//   single ram port is used once per item.
//   a stalled receiver holds the output; each pipeline stage keeps taking
//   items while it or the stage after it is free, so the input side stops
//   only once all five stages are full.
//   reset clears the pipeline valid bits and loads the identity matrix,
//   zero shift and a 256 x 256 frame; the frame store itself is not
//   cleared and an entry holds no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_nearest_image_warp_core import affw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [COORD_W-1:0]    in_col,
  input  wire logic [COORD_W-1:0]    in_row,
  input  wire logic [GRAY_W-1:0]     in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [GRAY_W-1:0]          out_pixel_out,
  output logic                       out_inside_res,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PW = (PIXEL_BITS > GRAY_W) ? PIXEL_BITS : GRAY_W;

  cfg_t            cfg;
  logic            map_valid;
  logic            map_ready;
  map_ctl_t        map_ctl;
  logic [AW-1:0]   map_addr;
  logic [GRAY_W-1:0] map_pix;

  logic            out_valid_r;
  logic            inside_r;
  logic            out_rdy;
  logic            ram_we;
  logic            ram_re;
  logic [PW-1:0]   wr_ext;
  logic [PW-1:0]   rd_ext;
  logic [PIXEL_BITS-1:0] ram_rdata;

  affw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  affw_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_op    (in_op),
    .s_col   (in_col),
    .s_row   (in_row),
    .s_pix   (in_pixel_in),
    .m_valid (map_valid),
    .m_ready (map_ready),
    .m_ctl   (map_ctl),
    .m_addr  (map_addr),
    .m_pix   (map_pix)
  );

  assign out_rdy   = !out_valid_r || out_ready;
  assign map_ready = out_rdy;
  assign ram_re    = map_valid && out_rdy;
  assign ram_we    = ram_re && map_ctl.wr_en;
  assign wr_ext    = PW'(map_pix);

  affw_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (map_addr),
    .wdata (wr_ext[PIXEL_BITS-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= map_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      inside_r <= map_ctl.in_frame;
    end
  end

  assign rd_ext         = PW'(ram_rdata);
  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;
  assign out_pixel_out  = inside_r ? rd_ext[GRAY_W-1:0] : '0;

endmodule

`default_nettype wire

>>> design/affw_checker.sv
// ----------------------------------------------------------------------------
// affw_checker
// port-level checks of the warp core result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module affw_checker import affw_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [GRAY_W-1:0]     out_pixel_out,
  input wire logic                  out_inside_res
);

  `AFFW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out_valid dropped in stall")

  `AFFW_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_pixel_out) && $stable(out_inside_res), "result changed in stall")

  `AFFW_ASSERT(a_outside_zero, out_valid && !out_inside_res |-> out_pixel_out == '0, "nonzero pixel outside frame")

  `AFFW_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind affine_nearest_image_warp_core affw_checker u_affw_checker (.*);

`default_nettype wire

>>> bench/affine_nearest_image_warp_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_nearest_image_warp_core_test
// self-checking bench for the affine nearest-neighbor warp core
// ----------------------------------------------------------------------------
// pixel writes and warped queries go into the core over valid/ready while
// a local copy of the frame store and of the matrix, shift and frame-size
// registers predicts each result. results are compared in order, field by
// field. directed corner cases come first, then random traffic under
// several matrix settings and idle profiles, and a long output stall.
// a query is only sent once its source pixel has been written.
// ----------------------------------------------------------------------------
module affine_nearest_image_warp_core_test;
  import affw_pkg::*;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_QUERY    = 1'b1;
  localparam int   FRAME_LIMIT = 256;
  localparam int   CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [GRAY_W-1:0] pixel;
    logic              in_frame;
  } warp_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_op;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic [GRAY_W-1:0] in_pixel_in;
  logic out_valid;
  logic out_ready;
  logic [GRAY_W-1:0] out_pixel_out;
  logic out_inside_res;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t warp_cfg;
  logic [GRAY_W-1:0] source_pixels [65536];
  bit pixel_written [65536];
  warp_result_t warp_results_due[$];

  int send_idle_pct;
  int recv_idle_pct;
  int receiver_hold_request;
  int receiver_hold_left;
  int error_count;
  int cycle_count;
  int n_writes;
  int n_queries;
  int n_inside;
  int n_reg_writes;

  affine_nearest_image_warp_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_inside_res (out_inside_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (receiver_hold_request > 0) begin
      receiver_hold_left = receiver_hold_request;
      receiver_hold_request = 0;
    end
    if (receiver_hold_left > 0) begin
      out_ready <= 1'b0;
      receiver_hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    warp_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (warp_results_due.size() == 0) begin
        report_mismatch("result with none due, pixel_out", out_pixel_out, 0);
      end else begin
        due = warp_results_due.pop_front();
        if (out_pixel_out !== due.pixel)
          report_mismatch("pixel_out", out_pixel_out, due.pixel);
        if (out_inside_res !== due.in_frame)
          report_mismatch("inside_res", out_inside_res, due.in_frame);
      end
    end
  end

  // inverse map of an output pixel, exact Q.16 source point
  function automatic logic map_source_point(input logic [COORD_W-1:0] col,
                                            input logic [COORD_W-1:0] row,
                                            output logic [15:0] addr);
    longint dx, dy, sx, sy, w, h;
    dx = longint'(col) * 16 - longint'($signed(warp_cfg.shift_x));
    dy = longint'(row) * 16 - longint'($signed(warp_cfg.shift_y));
    sx = longint'($signed(warp_cfg.m00)) * dx + longint'($signed(warp_cfg.m01)) * dy;
    sy = longint'($signed(warp_cfg.m10)) * dx + longint'($signed(warp_cfg.m11)) * dy;
    w = (warp_cfg.frame_width < FRAME_LIMIT) ? longint'(warp_cfg.frame_width) : FRAME_LIMIT;
    h = (warp_cfg.frame_height < FRAME_LIMIT) ? longint'(warp_cfg.frame_height) : FRAME_LIMIT;
    addr = {sy[23:16], sx[23:16]};
    return (sx >= 0) && (sy >= 0) && (sx < w * 65536) && (sy < h * 65536);
  endfunction

  function automatic int frame_extent(input logic [FRAME_W-1:0] size);
    return (size < FRAME_LIMIT) ? int'(size) : FRAME_LIMIT;
  endfunction

  task automatic send_item(input logic op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [GRAY_W-1:0] pix);
    warp_result_t due;
    logic [15:0] addr;
    due.pixel = '0;
    due.in_frame = 1'b0;
    if (op == OP_WRITE) begin
      source_pixels[{row, col}] = pix;
      pixel_written[{row, col}] = 1'b1;
      n_writes++;
    end else begin
      due.in_frame = map_source_point(col, row, addr);
      if (due.in_frame) begin
        due.pixel = source_pixels[addr];
        n_inside++;
      end
      n_queries++;
    end
    warp_results_due.push_back(due);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_col <= col;
    in_row <= row;
    in_pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  // writes the mapped source pixel first when it lies inside the frame and was never written
  task automatic send_query(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    logic [15:0] addr;
    if (map_source_point(col, row, addr) && !pixel_written[addr])
      send_item(OP_WRITE, addr[7:0], addr[15:8], 8'($urandom_range(255)));
    send_item(OP_QUERY, col, row, 8'($urandom_range(255)));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (warp_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_M00:          warp_cfg.m00 = data;
      CFG_M01:          warp_cfg.m01 = data;
      CFG_M10:          warp_cfg.m10 = data;
      CFG_M11:          warp_cfg.m11 = data;
      CFG_SHIFT_X:      warp_cfg.shift_x = data;
      CFG_SHIFT_Y:      warp_cfg.shift_y = data;
      CFG_FRAME_WIDTH:  warp_cfg.frame_width = data[FRAME_W-1:0];
      CFG_FRAME_HEIGHT: warp_cfg.frame_height = data[FRAME_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  task automatic configure_warp(input logic [15:0] m00, m01, m10, m11, sh_x, sh_y,
                                input logic [FRAME_W-1:0] w, h);
    write_register(CFG_M00, m00);
    write_register(CFG_M01, m01);
    write_register(CFG_M10, m10);
    write_register(CFG_M11, m11);
    write_register(CFG_SHIFT_X, sh_x);
    write_register(CFG_SHIFT_Y, sh_y);
    // upper data bits are don't-care for the frame size registers
    write_register(CFG_FRAME_WIDTH, {7'($urandom_range(127)), w});
    write_register(CFG_FRAME_HEIGHT, {7'($urandom_range(127)), h});
  endtask

  function automatic logic [15:0] extreme_value();
    case ($urandom_range(6))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return M_ONE;
      4: return -M_ONE;
      5: return 16'h0001;
      default: return 16'hffff;
    endcase
  endfunction

  task automatic load_random_warp();
    int pick, d00, d11, d01, d10, sx, sy;
    logic [FRAME_W-1:0] w, h;
    pick = $urandom_range(99);
    d00 = $urandom_range(6144) - 3072;
    d11 = $urandom_range(6144) - 3072;
    d01 = $urandom_range(4096) - 2048;
    d10 = $urandom_range(4096) - 2048;
    sx = $urandom_range(1024) - 512;
    sy = $urandom_range(1024) - 512;
    if (pick < 15) begin
      w = 9'($urandom_range(256, 1));
      h = 9'($urandom_range(256, 1));
      configure_warp(M_ONE, 16'h0, 16'h0, M_ONE, 16'h0, 16'h0, w, h);
    end else if (pick < 70) begin
      w = 9'($urandom_range(256, 8));
      h = 9'($urandom_range(256, 8));
      configure_warp(16'(4096 + d00), 16'(d01), 16'(d10), 16'(4096 + d11),
                     16'(sx), 16'(sy), w, h);
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0: w = 9'd0;
        1: w = 9'd1;
        2: w = FRAME_RESET;
        3: w = 9'd257;
        default: w = 9'd511;
      endcase
      h = ($urandom_range(1)) ? w : 9'($urandom_range(511));
      configure_warp(extreme_value(), extreme_value(), extreme_value(), extreme_value(),
                     extreme_value(), extreme_value(), w, h);
    end else begin
      configure_warp(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 9'($urandom_range(511)),
                     9'($urandom_range(511)));
    end
  endtask

  task automatic test_reset_and_corners();
    logic [15:0] addr;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // reset registers: identity, no shift, full frame
    send_item(OP_WRITE, 8'd0, 8'd0, 8'hff);
    send_item(OP_WRITE, 8'd255, 8'd0, 8'h00);
    send_item(OP_WRITE, 8'd0, 8'd255, 8'haa);
    send_item(OP_WRITE, 8'd255, 8'd255, 8'h55);
    send_item(OP_QUERY, 8'd0, 8'd0, 8'h00);
    send_item(OP_QUERY, 8'd255, 8'd0, 8'hff);
    send_item(OP_QUERY, 8'd0, 8'd255, 8'h00);
    send_item(OP_QUERY, 8'd255, 8'd255, 8'hff);
    // read right behind a write to the same pixel, then an overwrite
    send_item(OP_WRITE, 8'd10, 8'd20, 8'h5a);
    send_item(OP_QUERY, 8'd10, 8'd20, 8'h00);
    send_item(OP_WRITE, 8'd10, 8'd20, 8'ha5);
    send_item(OP_QUERY, 8'd10, 8'd20, 8'h00);
    drain_results();
    write_register(CFG_FRAME_WIDTH, 16'd0);
    send_item(OP_QUERY, 8'd0, 8'd0, 8'h00);
    drain_results();
    write_register(CFG_FRAME_WIDTH, 16'd300);
    write_register(CFG_FRAME_HEIGHT, 16'd511);
    send_item(OP_QUERY, 8'd255, 8'd255, 8'h00);
    drain_results();
    write_register(CFG_FRAME_WIDTH, 16'd1);
    write_register(CFG_FRAME_HEIGHT, 16'd1);
    send_item(OP_QUERY, 8'd0, 8'd0, 8'h00);
    send_item(OP_QUERY, 8'd1, 8'd0, 8'h00);
    send_item(OP_QUERY, 8'd0, 8'd1, 8'h00);
    drain_results();
    write_register(CFG_FRAME_WIDTH, 16'd256);
    write_register(CFG_FRAME_HEIGHT, 16'd256);
    write_register(CFG_SHIFT_X, 16'd16);
    write_register(CFG_SHIFT_Y, -16'sd16);
    send_item(OP_QUERY, 8'd0, 8'd0, 8'h00);
    send_query(8'd1, 8'd5);
    drain_results();
    // mirror about the left edge
    configure_warp(-M_ONE, 16'h0, 16'h0, M_ONE, 16'h0, 16'h0, 9'd256, 9'd256);
    send_item(OP_QUERY, 8'd0, 8'd0, 8'h00);
    send_item(OP_QUERY, 8'd1, 8'd0, 8'h00);
    drain_results();
    // half scale, truncation of the source point
    configure_warp(16'd2048, 16'h0, 16'h0, 16'd2048, 16'h0, 16'h0, 9'd256, 9'd256);
    send_query(8'd3, 8'd3);
    void'(map_source_point(8'd3, 8'd3, addr));
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int i, eff_w, eff_h, wmax_c, wmax_r, qmax_c, qmax_r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        drain_results();
        load_random_warp();
      end
      eff_w = frame_extent(warp_cfg.frame_width);
      eff_h = frame_extent(warp_cfg.frame_height);
      wmax_c = (eff_w > 0) ? eff_w - 1 : 255;
      wmax_r = (eff_h > 0) ? eff_h - 1 : 255;
      qmax_c = (eff_w * 2 + 8 > 255) ? 255 : eff_w * 2 + 8;
      qmax_r = (eff_h * 2 + 8 > 255) ? 255 : eff_h * 2 + 8;
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(99) < 80)
          send_item(OP_WRITE, 8'($urandom_range(wmax_c)), 8'($urandom_range(wmax_r)),
                    8'($urandom_range(255)));
        else
          send_item(OP_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      end else if ($urandom_range(1)) begin
        send_query(8'($urandom_range(qmax_c)), 8'($urandom_range(qmax_r)));
      end else begin
        send_query(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
    drain_results();
  endtask

  task automatic test_output_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure_warp(M_ONE, 16'h0, 16'h0, M_ONE, 16'h0, 16'h0, 9'd256, 9'd256);
    receiver_hold_request = 64;
    for (i = 0; i < 40; i++)
      send_query(8'($urandom_range(255)), 8'($urandom_range(255)));
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_WRITE;
    in_col = '0;
    in_row = '0;
    in_pixel_in = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_M00;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    receiver_hold_request = 0;
    receiver_hold_left = 0;
    error_count = 0;
    cycle_count = 0;
    n_writes = 0;
    n_queries = 0;
    n_inside = 0;
    n_reg_writes = 0;
    warp_cfg = '{m00: M_ONE, m01: '0, m10: '0, m11: M_ONE, shift_x: '0, shift_y: '0,
                 frame_width: FRAME_RESET, frame_height: FRAME_RESET};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_corners();
    test_random_traffic(17, 46, 400);
    test_random_traffic(46, 17, 400);
    test_random_traffic(0, 0, 400);
    test_output_backpressure();

    repeat (10) @(posedge clk);
    $display("covered %0d pixel writes, %0d warped queries (%0d inside the frame)",
             n_writes, n_queries, n_inside);
    $display("and %0d register writes across three idle profiles and a long output hold",
             n_reg_writes);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", error_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> affine_nearest_image_warp_core.f
+incdir+design
design/affw_pkg.sv
design/affw_ram.sv
design/affw_cfg.sv
design/affw_map.sv
design/affine_nearest_image_warp_core.sv
design/affw_checker.sv
bench/affine_nearest_image_warp_core_test.sv
